### rtl/rpce_pkg.sv
// Shared types, constants and effect codes for the region pixel color effect block.
`timescale 1ns / 1ps

package rpce_pkg;

  localparam int PIX_W          = 8;
  localparam int COORD_W        = 12;
  localparam int SPAN_W         = 13;
  localparam int AMT_W          = 9;
  localparam int SUM_W          = 10;
  localparam int FACTOR_W       = 24;
  localparam int REG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 13;
  localparam int MAX_IMAGE_SIDE = 4096;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(65536);

  localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AMOUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TOP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPAN_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPAN_Y = 3'd5;

  typedef enum logic [2:0] {
    MODE_INV_GREY = 3'd0,
    MODE_INVERT   = 3'd1,
    MODE_GREY     = 3'd2,
    MODE_BRIGHT   = 3'd3,
    MODE_CONTRAST = 3'd4,
    MODE_RED      = 3'd5,
    MODE_GREEN    = 3'd6,
    MODE_BLUE     = 3'd7
  } mode_e;

  typedef struct packed {
    logic  in_rect;
    mode_e mode;
  } ctl_t;

endpackage

### rtl/rpce_div.sv
// Bit-serial divider that derives the Q8.16 contrast factor from the amount.
`timescale 1ns / 1ps

module rpce_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [rpce_pkg::AMT_W-1:0]    amount_i,
  output logic                                 busy_o,
  output logic        [rpce_pkg::FACTOR_W-1:0] factor_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam int   STEPS   = rpce_pkg::FACTOR_W;
  localparam int   CNT_W   = $clog2(STEPS);

  logic                              state_q, state_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [16:0]                       rem_q, rem_d;
  logic [16:0]                       den_q, den_d;
  logic [rpce_pkg::FACTOR_W-1:0]     sh_q, sh_d;
  logic [rpce_pkg::FACTOR_W-1:0]     quo_q, quo_d;
  logic [rpce_pkg::FACTOR_W-1:0]     factor_q, factor_d;

  logic [9:0]  a_plus;
  logic [9:0]  a_minus;
  logic [17:0] num;
  logic [16:0] den;
  logic [17:0] trial;
  logic        ge;

  assign a_plus  = 10'($signed({amount_i[rpce_pkg::AMT_W-1], amount_i}) + 10'sd255);
  assign a_minus = 10'(10'sd259 - $signed({amount_i[rpce_pkg::AMT_W-1], amount_i}));
  assign num     = 18'(a_plus) * 18'd259;
  assign den     = 17'(a_minus) * 17'd255;

  assign trial = {rem_q, sh_q[rpce_pkg::FACTOR_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    den_d    = den_q;
    sh_d     = sh_q;
    quo_d    = quo_q;
    factor_d = factor_q;
    case (state_q)
      ST_IDLE: ;
      ST_RUN: begin
        rem_d = ge ? 17'(trial - {1'b0, den_q}) : trial[16:0];
        sh_d  = {sh_q[rpce_pkg::FACTOR_W-2:0], 1'b0};
        quo_d = {quo_q[rpce_pkg::FACTOR_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          state_d  = ST_IDLE;
          factor_d = quo_d;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // restart on every new amount, even while a division runs
    if (start_i) begin
      state_d = ST_RUN;
      cnt_d   = '0;
      rem_d   = 17'(num[17:8]);
      den_d   = den;
      sh_d    = {num[7:0], 16'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      factor_q <= rpce_pkg::FACTOR_RESET;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      factor_q <= factor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign busy_o   = (state_q == ST_RUN);
  assign factor_o = factor_q;

endmodule

### rtl/rpce_lane.sv
// One color channel lane: point operations on a single channel over two stages.
`timescale 1ns / 1ps

module rpce_lane (
  input  logic                                 clk_i,
  input  logic                                 ld1_i,
  input  logic                                 ld2_i,
  input  logic        [rpce_pkg::PIX_W-1:0]    chan_i,
  input  rpce_pkg::mode_e                      mode_i,
  input  logic signed [rpce_pkg::AMT_W-1:0]    amount_i,
  input  logic        [rpce_pkg::FACTOR_W-1:0] factor_i,
  input  rpce_pkg::ctl_t                       ctl_i,
  input  logic                                 hit_i,
  input  logic        [rpce_pkg::PIX_W-1:0]    grey_i,
  output logic        [rpce_pkg::PIX_W-1:0]    chan_o
);

  localparam int PROD_W = rpce_pkg::FACTOR_W + rpce_pkg::PIX_W;

  logic        [rpce_pkg::PIX_W-1:0] chan_q;
  logic signed [9:0]                 add_q, add_d;
  logic        [PROD_W-1:0]          prod_q, prod_d;
  logic                              neg_q;
  logic        [rpce_pkg::PIX_W-1:0] res_q, res_d;

  logic        [rpce_pkg::PIX_W-1:0] dev;
  logic signed [9:0]                 c_ext;
  logic signed [9:0]                 a_ext;
  logic        [15:0]                mag;
  logic        [rpce_pkg::PIX_W-1:0] ctr;
  logic        [rpce_pkg::PIX_W-1:0] clip;

  assign c_ext = $signed({2'b00, chan_i});
  assign a_ext = 10'($signed(amount_i));
  assign add_d = (mode_i == rpce_pkg::MODE_BRIGHT) ? 10'(c_ext + a_ext) : 10'(c_ext - a_ext);
  assign dev   = chan_i[7] ? {1'b0, chan_i[6:0]} : 8'(8'd128 - chan_i);
  assign prod_d = PROD_W'(factor_i) * PROD_W'(dev);

  always_ff @(posedge clk_i) begin
    if (ld1_i) begin
      chan_q <= chan_i;
      add_q  <= add_d;
      prod_q <= prod_d;
      neg_q  <= ~chan_i[7];
    end
  end

  assign mag = prod_q[PROD_W-1:16];

  always_comb begin
    if (neg_q) begin
      ctr = (mag > 16'd128) ? 8'd0 : 8'(16'd128 - mag);
    end else begin
      ctr = (mag > 16'd127) ? 8'd255 : 8'(16'd128 + mag);
    end
    if (add_q < 0) begin
      clip = 8'd0;
    end else if (add_q > 10'sd255) begin
      clip = 8'd255;
    end else begin
      clip = add_q[7:0];
    end
  end

  always_comb begin
    res_d = chan_q;
    if (ctl_i.in_rect) begin
      case (ctl_i.mode)
        rpce_pkg::MODE_INV_GREY: res_d = grey_i;
        rpce_pkg::MODE_GREY:     res_d = grey_i;
        rpce_pkg::MODE_INVERT:   res_d = ~chan_q;
        rpce_pkg::MODE_BRIGHT:   res_d = clip;
        rpce_pkg::MODE_CONTRAST: res_d = ctr;
        default:                 res_d = hit_i ? clip : chan_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2_i) begin
      res_q <= res_d;
    end
  end

  assign chan_o = res_q;

endmodule

### rtl/region_pixel_color_effect.sv
// Top level: configuration registers, region test, grey merge and pipeline control.
`timescale 1ns / 1ps

// Applies a point color effect to each RGB pixel whose position falls inside a configured
// rectangle and passes other pixels through. Three channel lanes work side by side and a
// grey merge combines the channels for the grey modes. One item is accepted every cycle
// unless the output backs up or the divider is busy; after each write to the amount
// register the input stalls while a bit-serial divider recomputes the contrast factor.
module region_pixel_color_effect (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rpce_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rpce_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rpce_pkg::COORD_W-1:0]       pixel_x_i,
  input  logic [rpce_pkg::COORD_W-1:0]       pixel_y_i,
  input  logic [rpce_pkg::PIX_W-1:0]         red_in_i,
  input  logic [rpce_pkg::PIX_W-1:0]         green_in_i,
  input  logic [rpce_pkg::PIX_W-1:0]         blue_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rpce_pkg::PIX_W-1:0]         red_out_o,
  output logic [rpce_pkg::PIX_W-1:0]         green_out_o,
  output logic [rpce_pkg::PIX_W-1:0]         blue_out_o
);

  localparam int BOUND_W = rpce_pkg::COORD_W + 2;

  rpce_pkg::mode_e                          mode_q;
  logic signed [rpce_pkg::AMT_W-1:0]        amount_q;
  logic        [rpce_pkg::COORD_W-1:0]      left_q;
  logic        [rpce_pkg::COORD_W-1:0]      top_q;
  logic        [rpce_pkg::SPAN_W-1:0]       span_x_q;
  logic        [rpce_pkg::SPAN_W-1:0]       span_y_q;
  logic                                     start_q;

  logic                                     v1_q;
  logic                                     vo_q;
  rpce_pkg::ctl_t                           ctl_q, ctl_d;
  logic        [2:0]                        hit_q, hit_d;
  logic        [rpce_pkg::SUM_W-1:0]        tot_q, tot_d;

  logic signed [rpce_pkg::AMT_W-1:0]        amount_sat;
  logic        [rpce_pkg::FACTOR_W-1:0]     factor;
  logic                                     div_busy;
  logic        [rpce_pkg::SPAN_W-1:0]       span_x_sat;
  logic        [rpce_pkg::SPAN_W-1:0]       span_y_sat;
  logic        [BOUND_W-1:0]                right;
  logic        [BOUND_W-1:0]                bottom;
  logic        [rpce_pkg::SUM_W-1:0]        sum;
  logic        [19:0]                       grey_prod;
  logic        [rpce_pkg::PIX_W-1:0]        grey;
  logic                                     adv_o;
  logic                                     adv_1;
  logic                                     accept;
  logic                                     ld2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rpce_pkg::MODE_INVERT;
      amount_q <= '0;
      left_q   <= '0;
      top_q    <= '0;
      span_x_q <= '0;
      span_y_q <= '0;
      start_q  <= 1'b0;
    end else begin
      start_q <= cfg_we_i && (cfg_idx_i == rpce_pkg::REG_AMOUNT);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rpce_pkg::REG_MODE:   mode_q   <= rpce_pkg::mode_e'(cfg_data_i[2:0]);
          rpce_pkg::REG_AMOUNT: amount_q <= $signed(cfg_data_i[rpce_pkg::AMT_W-1:0]);
          rpce_pkg::REG_LEFT:   left_q   <= cfg_data_i[rpce_pkg::COORD_W-1:0];
          rpce_pkg::REG_TOP:    top_q    <= cfg_data_i[rpce_pkg::COORD_W-1:0];
          rpce_pkg::REG_SPAN_X: span_x_q <= cfg_data_i[rpce_pkg::SPAN_W-1:0];
          rpce_pkg::REG_SPAN_Y: span_y_q <= cfg_data_i[rpce_pkg::SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign amount_sat = (amount_q == -9'sd256) ? -9'sd255 : amount_q;

  rpce_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .amount_i (amount_sat),
    .busy_o   (div_busy),
    .factor_o (factor)
  );

  assign span_x_sat = (span_x_q > rpce_pkg::SPAN_W'(rpce_pkg::MAX_IMAGE_SIDE))
                      ? rpce_pkg::SPAN_W'(rpce_pkg::MAX_IMAGE_SIDE) : span_x_q;
  assign span_y_sat = (span_y_q > rpce_pkg::SPAN_W'(rpce_pkg::MAX_IMAGE_SIDE))
                      ? rpce_pkg::SPAN_W'(rpce_pkg::MAX_IMAGE_SIDE) : span_y_q;
  assign right  = BOUND_W'(left_q) + BOUND_W'(span_x_sat);
  assign bottom = BOUND_W'(top_q) + BOUND_W'(span_y_sat);

  assign adv_o      = !vo_q || !out_stall_i;
  assign adv_1      = !v1_q || adv_o;
  assign in_stall_o = !adv_1 || div_busy || start_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign ld2        = adv_o && v1_q;

  assign sum = rpce_pkg::SUM_W'(red_in_i) + rpce_pkg::SUM_W'(green_in_i)
             + rpce_pkg::SUM_W'(blue_in_i);

  always_comb begin
    ctl_d.in_rect = (pixel_x_i >= left_q) && (BOUND_W'(pixel_x_i) < right)
                 && (pixel_y_i >= top_q) && (BOUND_W'(pixel_y_i) < bottom);
    ctl_d.mode   = mode_q;
    hit_d[0]     = (mode_q == rpce_pkg::MODE_GREEN) || (mode_q == rpce_pkg::MODE_BLUE);
    hit_d[1]     = (mode_q == rpce_pkg::MODE_RED) || (mode_q == rpce_pkg::MODE_BLUE);
    hit_d[2]     = (mode_q == rpce_pkg::MODE_RED) || (mode_q == rpce_pkg::MODE_GREEN);
    tot_d        = (mode_q == rpce_pkg::MODE_INV_GREY) ? rpce_pkg::SUM_W'(10'd765 - sum) : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv_1) begin
        v1_q <= accept;
      end
      if (adv_o) begin
        vo_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_q <= ctl_d;
      hit_q <= hit_d;
      tot_q <= tot_d;
    end
  end

  // divide by three: multiply by 683 / 2048, exact for sums up to 765
  assign grey_prod = 20'(tot_q) * 20'd683;
  assign grey      = grey_prod[18:11];

  rpce_lane u_lane_red (
    .clk_i    (clk_i),
    .ld1_i    (accept),
    .ld2_i    (ld2),
    .chan_i   (red_in_i),
    .mode_i   (mode_q),
    .amount_i (amount_sat),
    .factor_i (factor),
    .ctl_i    (ctl_q),
    .hit_i    (hit_q[0]),
    .grey_i   (grey),
    .chan_o   (red_out_o)
  );

  rpce_lane u_lane_green (
    .clk_i    (clk_i),
    .ld1_i    (accept),
    .ld2_i    (ld2),
    .chan_i   (green_in_i),
    .mode_i   (mode_q),
    .amount_i (amount_sat),
    .factor_i (factor),
    .ctl_i    (ctl_q),
    .hit_i    (hit_q[1]),
    .grey_i   (grey),
    .chan_o   (green_out_o)
  );

  rpce_lane u_lane_blue (
    .clk_i    (clk_i),
    .ld1_i    (accept),
    .ld2_i    (ld2),
    .chan_i   (blue_in_i),
    .mode_i   (mode_q),
    .amount_i (amount_sat),
    .factor_i (factor),
    .ctl_i    (ctl_q),
    .hit_i    (hit_q[2]),
    .grey_i   (grey),
    .chan_o   (blue_out_o)
  );

  assign out_valid_o = vo_q;

endmodule

### bench/rpce_checker.sv
// Checker: mirrors the register file, predicts each pixel and compares the output stream.
`timescale 1ns / 1ps

module rpce_checker
  import rpce_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [COORD_W-1:0]    pixel_x_i,
  input  logic [COORD_W-1:0]    pixel_y_i,
  input  logic [PIX_W-1:0]      red_in_i,
  input  logic [PIX_W-1:0]      green_in_i,
  input  logic [PIX_W-1:0]      blue_in_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [PIX_W-1:0]      red_out_i,
  input  logic [PIX_W-1:0]      green_out_i,
  input  logic [PIX_W-1:0]      blue_out_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  mode_e                    cur_mode;
  logic signed [AMT_W-1:0]  cur_amount;
  logic [COORD_W-1:0]       cur_left;
  logic [COORD_W-1:0]       cur_top;
  logic [SPAN_W-1:0]        cur_span_x;
  logic [SPAN_W-1:0]        cur_span_y;

  rgb_t expected_pixels[$];
  rgb_t seen_px;
  rgb_t want_px;
  int   fail_count = 0;
  int   pending = 0;
  int   checked = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;

  function automatic logic [PIX_W-1:0] clamp_byte(longint v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[PIX_W-1:0];
  endfunction

  function automatic longint unsigned contrast_factor(int a);
    longint unsigned num;
    longint unsigned den;
    num = longint'(259 * (a + 255)) << 16;
    den = longint'(255 * (259 - a));
    return num / den;
  endfunction

  function automatic logic [PIX_W-1:0] contrast_lane(longint unsigned factor,
                                                     logic [PIX_W-1:0] c);
    longint unsigned dev;
    longint          mag;
    if (c >= 8'd128) begin
      dev = 64'(c) - 64'd128;
      mag = longint'((factor * dev) >> 16);
    end else begin
      dev = 64'd128 - 64'(c);
      mag = -longint'((factor * dev) >> 16);
    end
    return clamp_byte(128 + mag);
  endfunction

  function automatic rgb_t shade_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                       rgb_t p);
    int              a;
    int              sx;
    int              sy;
    int              r;
    int              g;
    int              b;
    int              grey;
    bit              in_region;
    longint unsigned factor;
    rgb_t            q;
    a  = int'(cur_amount);
    if (a < -255) a = -255;
    sx = (cur_span_x > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : int'(cur_span_x);
    sy = (cur_span_y > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : int'(cur_span_y);
    r  = int'(p.red);
    g  = int'(p.green);
    b  = int'(p.blue);
    in_region = int'(x) >= int'(cur_left) && int'(x) < int'(cur_left) + sx &&
                int'(y) >= int'(cur_top) && int'(y) < int'(cur_top) + sy;
    q = p;
    if (in_region) begin
      case (cur_mode)
        MODE_INV_GREY: begin
          grey = (765 - r - g - b) / 3;
          q = '{grey[7:0], grey[7:0], grey[7:0]};
        end
        MODE_INVERT: begin
          q = '{~p.red, ~p.green, ~p.blue};
        end
        MODE_GREY: begin
          grey = (r + g + b) / 3;
          q = '{grey[7:0], grey[7:0], grey[7:0]};
        end
        MODE_BRIGHT: begin
          q = '{clamp_byte(r + a), clamp_byte(g + a), clamp_byte(b + a)};
        end
        MODE_CONTRAST: begin
          factor = contrast_factor(a);
          q = '{contrast_lane(factor, p.red), contrast_lane(factor, p.green),
                contrast_lane(factor, p.blue)};
        end
        MODE_RED: begin
          q.green = clamp_byte(g - a);
          q.blue  = clamp_byte(b - a);
        end
        MODE_GREEN: begin
          q.red  = clamp_byte(r - a);
          q.blue = clamp_byte(b - a);
        end
        default: begin
          q.red   = clamp_byte(r - a);
          q.green = clamp_byte(g - a);
        end
      endcase
    end
    return q;
  endfunction

  task automatic check_lane(string lane, logic [PIX_W-1:0] want, logic [PIX_W-1:0] seen);
    if (seen !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, lane, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode   <= MODE_INVERT;
      cur_amount <= '0;
      cur_left   <= '0;
      cur_top    <= '0;
      cur_span_x <= '0;
      cur_span_y <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   cur_mode   <= mode_e'(cfg_data_i[2:0]);
        REG_AMOUNT: cur_amount <= cfg_data_i[AMT_W-1:0];
        REG_LEFT:   cur_left   <= cfg_data_i[COORD_W-1:0];
        REG_TOP:    cur_top    <= cfg_data_i[COORD_W-1:0];
        REG_SPAN_X: cur_span_x <= cfg_data_i[SPAN_W-1:0];
        REG_SPAN_Y: cur_span_y <= cfg_data_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pixels.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen_px = '{red_out_i, green_out_i, blue_out_i};
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected pixel %0d/%0d/%0d", $time,
                     seen_px.red, seen_px.green, seen_px.blue);
        end else begin
          want_px = expected_pixels.pop_front();
          checked++;
          check_lane("red", want_px.red, seen_px.red);
          check_lane("green", want_px.green, seen_px.green);
          check_lane("blue", want_px.blue, seen_px.blue);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_pixels.push_back(shade_pixel(pixel_x_i, pixel_y_i,
                                              '{red_in_i, green_in_i, blue_in_i}));
      pending = expected_pixels.size();
    end
  end

endmodule

### bench/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the region pixel color effect block.
`timescale 1ns / 1ps

module testbench;
  import rpce_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 625;

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic [COORD_W-1:0]    pixel_x = '0;
  logic [COORD_W-1:0]    pixel_y = '0;
  logic [PIX_W-1:0]      red_in = '0;
  logic [PIX_W-1:0]      green_in = '0;
  logic [PIX_W-1:0]      blue_in = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [PIX_W-1:0]      red_out;
  logic [PIX_W-1:0]      green_out;
  logic [PIX_W-1:0]      blue_out;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;
  int pixels_sent = 0;
  int settings_used = 0;

  logic [COORD_W-1:0] win_left = '0;
  logic [COORD_W-1:0] win_top = '0;
  logic [SPAN_W-1:0]  win_span_x = '0;
  logic [SPAN_W-1:0]  win_span_y = '0;

  region_pixel_color_effect i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_x_i   (pixel_x),
    .pixel_y_i   (pixel_y),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .red_out_o   (red_out),
    .green_out_o (green_out),
    .blue_out_o  (blue_out)
  );

  rpce_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .red_out_i    (red_out),
    .green_out_i  (green_out),
    .blue_out_i   (blue_out),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] mode_data,
                               logic [CFG_DATA_W-1:0] amount_data,
                               logic [CFG_DATA_W-1:0] left, logic [CFG_DATA_W-1:0] top,
                               logic [CFG_DATA_W-1:0] span_x,
                               logic [CFG_DATA_W-1:0] span_y);
    wait_drained();
    write_reg(REG_MODE, mode_data);
    write_reg(REG_LEFT, left);
    write_reg(REG_TOP, top);
    write_reg(REG_SPAN_X, span_x);
    write_reg(REG_SPAN_Y, span_y);
    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
    write_reg(REG_AMOUNT, amount_data);
    cfg_we     <= 1'b0;
    win_left   = left[COORD_W-1:0];
    win_top    = top[COORD_W-1:0];
    win_span_x = span_x[SPAN_W-1:0];
    win_span_y = span_y[SPAN_W-1:0];
    settings_used++;
  endtask

  task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] lo,
                                                    logic [SPAN_W-1:0] span);
    int bound_hi;
    int v;
    bound_hi = int'(lo) + ((span > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : int'(span));
    case ($urandom_range(4))
      0:       v = $urandom_range(4095);
      1:       v = int'(lo) - 2 + int'($urandom_range(4));
      2:       v = bound_hi - 2 + int'($urandom_range(4));
      3:       v = $urandom_range(bound_hi, int'(lo));
      default: v = $urandom_range(1) ? 4095 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] pick_channel();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return PIX_W'($urandom_range(129, 127));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_span();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DATA_W'(MAX_IMAGE_SIDE);
      2:       return CFG_DATA_W'($urandom);
      3:       return CFG_DATA_W'($urandom_range(64, 1));
      default: return CFG_DATA_W'($urandom_range(MAX_IMAGE_SIDE));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_origin();
    logic [COORD_W-1:0] v;
    case ($urandom_range(3))
      0:       v = '0;
      1:       v = '1;
      2:       v = COORD_W'($urandom_range(63));
      default: v = COORD_W'($urandom);
    endcase
    return {1'($urandom), v};
  endfunction

  task automatic random_setting();
    logic [AMT_W-1:0] amt;
    case ($urandom_range(6))
      0:       amt = 9'h100;
      1:       amt = 9'h101;
      2:       amt = 9'h0ff;
      3:       amt = 9'h000;
      default: amt = AMT_W'($urandom);
    endcase
    apply_setting(CFG_DATA_W'($urandom), {4'($urandom), amt}, pick_origin(), pick_origin(),
                  pick_span(), pick_span());
  endtask

  initial begin
    mode_e                 md;
    logic [CFG_DATA_W-1:0] amt;
    int                    burst;
    int                    left_todo;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // empty region after reset: pass through
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0, 8'd170);

    md = md.first();
    repeat (8) begin
      case (md)
        MODE_BRIGHT:   amt = 13'h0ff;
        MODE_CONTRAST: amt = 13'h100; // most negative pattern saturates: flat grey
        MODE_RED:      amt = 13'h101;
        MODE_GREEN:    amt = 13'h0ff;
        MODE_BLUE:     amt = 13'h040;
        default:       amt = CFG_DATA_W'($urandom);
      endcase
      // oversized x span saturates to the full image side
      apply_setting(CFG_DATA_W'(md), amt, '0, '0, 13'h1fff, CFG_DATA_W'(MAX_IMAGE_SIDE));
      send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd2048, 12'd1, 8'd128, 8'd127, 8'd1);
      md = md.next();
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct <= 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct <= 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      left_todo = RANDOM_PER_PHASE;
      while (left_todo > 0) begin
        random_setting();
        // hold the output while items keep coming, so the input backs up
        if (phase == 2) hold_go <= 1'b1;
        burst = $urandom_range(80, 20);
        if (burst > left_todo) burst = left_todo;
        repeat (burst)
          send_pixel(pick_coord(win_left, win_span_x), pick_coord(win_top, win_span_y),
                     pick_channel(), pick_channel(), pick_channel());
        left_todo -= burst;
      end
    end

    wait_drained();
    $display("Sent %0d pixels over %0d register settings: all effects, region edges,",
             pixels_sent, settings_used);
    $display("a %0d-cycle output hold and drain pauses; %0d results checked.",
             HOLD_CYCLES, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("region_pixel_color_effect verification clean");
    end else begin
      $display("region_pixel_color_effect verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run did not complete in time");
    $display("region_pixel_color_effect verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/rpce_pkg.sv
rtl/rpce_div.sv
rtl/rpce_lane.sv
rtl/region_pixel_color_effect.sv
bench/rpce_checker.sv
bench/testbench.sv
